FILE: sv/tsvc_pkg.sv
// Package for the typed scan value compare block.
// Holds configuration types, register and code constants, pipeline depth.
// No dependencies.
package tsvc_pkg;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;
  localparam int FADD_STAGES = 6;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_TYPE = 2'd1;
  localparam logic [1:0] REG_SCAN = 2'd2;
  localparam logic [1:0] REG_LEN  = 2'd3;

  localparam logic [3:0] MODE_EXACT     = 4'd0;
  localparam logic [3:0] MODE_FUZZY     = 4'd1;
  localparam logic [3:0] MODE_GREATER   = 4'd2;
  localparam logic [3:0] MODE_LESS      = 4'd3;
  localparam logic [3:0] MODE_BETWEEN   = 4'd4;
  localparam logic [3:0] MODE_INCR      = 4'd5;
  localparam logic [3:0] MODE_INCR_BY   = 4'd6;
  localparam logic [3:0] MODE_DECR      = 4'd7;
  localparam logic [3:0] MODE_DECR_BY   = 4'd8;
  localparam logic [3:0] MODE_CHANGED   = 4'd9;
  localparam logic [3:0] MODE_UNCHANGED = 4'd10;

  localparam logic [3:0] TYPE_U8  = 4'd0;
  localparam logic [3:0] TYPE_I8  = 4'd1;
  localparam logic [3:0] TYPE_U16 = 4'd2;
  localparam logic [3:0] TYPE_I16 = 4'd3;
  localparam logic [3:0] TYPE_U32 = 4'd4;
  localparam logic [3:0] TYPE_I32 = 4'd5;
  localparam logic [3:0] TYPE_U64 = 4'd6;
  localparam logic [3:0] TYPE_I64 = 4'd7;
  localparam logic [3:0] TYPE_F32 = 4'd8;
  localparam logic [3:0] TYPE_F64 = 4'd9;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  vtype;
    logic [63:0] scan;
    logic [3:0]  len;
  } cfg_t;

  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
    logic ne;
  } rel_t;

endpackage

FILE: sv/tsvc_cfg.sv
// APB-style configuration registers for the typed scan value compare block.
// Depends on tsvc_pkg.
module tsvc_cfg
  import tsvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[4:3];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_EXACT;
      cfg_r.vtype <= TYPE_U8;
      cfg_r.scan  <= '0;
      cfg_r.len   <= 4'd1;
    end else if (wr) begin
      unique case (idx)
        REG_MODE: cfg_r.mode  <= pwdata[3:0];
        REG_TYPE: cfg_r.vtype <= pwdata[3:0];
        REG_SCAN: cfg_r.scan  <= pwdata;
        REG_LEN:  cfg_r.len   <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE: prdata = {60'b0, cfg_r.mode};
      REG_TYPE: prdata = {60'b0, cfg_r.vtype};
      REG_SCAN: prdata = cfg_r.scan;
      REG_LEN:  prdata = {60'b0, cfg_r.len};
    endcase
  end

endmodule

FILE: sv/tsvc_fadd.sv
// Six-stage IEEE single/double adder, round to nearest even.
// Stages: unpack/swap, align, add, leading-zero count, normalize, round/pack.
// Depends on tsvc_pkg.
module tsvc_fadd
  import tsvc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic        dbl,
  input  logic        sub,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic [63:0] res_bits,
  output logic        res_small
);

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        dbl;
    logic        sub;
    logic [11:0] e;
  } ctl_t;

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    n = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (v[i]) n = 6'(55 - i);
    end
    return n;
  endfunction

  // unpack and order by magnitude
  logic [10:0] emax, xa, xb, ea, eb;
  logic [51:0] fa, fb;
  logic        sa, sb, nan_a, nan_b, inf_a, inf_b, a_ge;
  logic [52:0] ma, mb;
  ctl_t        u_ctl_nxt;
  ctl_t        u_ctl_r, a_ctl_r, s_ctl_r, l_ctl_r, n_ctl_r;
  logic [52:0] u_mb_r, u_ms_r;
  logic [10:0] u_d_r;

  always_comb begin
    emax  = dbl ? 11'h7FF : 11'h0FF;
    xa    = dbl ? op_a[62:52] : {3'b0, op_a[30:23]};
    xb    = dbl ? op_b[62:52] : {3'b0, op_b[30:23]};
    fa    = dbl ? op_a[51:0] : {op_a[22:0], 29'b0};
    fb    = dbl ? op_b[51:0] : {op_b[22:0], 29'b0};
    sa    = dbl ? op_a[63] : op_a[31];
    sb    = (dbl ? op_b[63] : op_b[31]) ^ sub;
    ea    = (xa == 11'd0) ? 11'd1 : xa;
    eb    = (xb == 11'd0) ? 11'd1 : xb;
    ma    = {xa != 11'd0, fa};
    mb    = {xb != 11'd0, fb};
    nan_a = (xa == emax) && (fa != 52'd0);
    nan_b = (xb == emax) && (fb != 52'd0);
    inf_a = (xa == emax) && (fa == 52'd0);
    inf_b = (xb == emax) && (fb == 52'd0);
    a_ge  = {ea, ma} >= {eb, mb};
    u_ctl_nxt.nan  = nan_a | nan_b | (inf_a & inf_b & (sa != sb));
    u_ctl_nxt.inf  = inf_a | inf_b;
    u_ctl_nxt.sign = a_ge ? sa : sb;
    u_ctl_nxt.dbl  = dbl;
    u_ctl_nxt.sub  = sa ^ sb;
    u_ctl_nxt.e    = {1'b0, a_ge ? ea : eb};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_ctl_r <= u_ctl_nxt;
      u_mb_r  <= a_ge ? ma : mb;
      u_ms_r  <= a_ge ? mb : ma;
      u_d_r   <= a_ge ? (ea - eb) : (eb - ea);
    end
  end

  // align the smaller operand, sticky folded into bit 0
  logic [55:0] ext, shifted, lost;
  logic [55:0] a_sml_nxt;
  logic        sticky;
  logic [55:0] a_big_r, a_sml_r;

  always_comb begin
    ext     = {u_ms_r, 3'b0};
    shifted = ext >> u_d_r[5:0];
    lost    = ext & ~({56{1'b1}} << u_d_r[5:0]);
    if (u_d_r >= 11'd56) begin
      shifted = '0;
      sticky  = |u_ms_r;
    end else begin
      sticky  = |lost;
    end
    a_sml_nxt = {shifted[55:1], shifted[0] | sticky};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl_r <= u_ctl_r;
      a_big_r <= {u_mb_r, 3'b0};
      a_sml_r <= a_sml_nxt;
    end
  end

  // magnitude add or subtract
  logic [56:0] s_sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_ctl_r <= a_ctl_r;
      s_sum_r <= a_ctl_r.sub ? ({1'b0, a_big_r} - {1'b0, a_sml_r})
                             : ({1'b0, a_big_r} + {1'b0, a_sml_r});
    end
  end

  // leading zero count
  logic [56:0] l_sum_r;
  logic [5:0]  l_lz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l_ctl_r <= s_ctl_r;
      l_sum_r <= s_sum_r;
      l_lz_r  <= lzc56(s_sum_r[55:0]);
    end
  end

  // normalize, left shift limited by the minimum exponent
  logic [11:0] lim;
  logic [5:0]  sh;
  logic [55:0] n_m_nxt;
  ctl_t        n_ctl_nxt;
  logic [55:0] n_m_r;

  always_comb begin
    n_ctl_nxt = l_ctl_r;
    lim       = l_ctl_r.e - 12'd1;
    sh        = ({6'b0, l_lz_r} < lim) ? l_lz_r : lim[5:0];
    if (l_sum_r[56]) begin
      n_m_nxt     = {l_sum_r[56:2], l_sum_r[1] | l_sum_r[0]};
      n_ctl_nxt.e = l_ctl_r.e + 12'd1;
    end else begin
      n_m_nxt     = l_sum_r[55:0] << sh;
      n_ctl_nxt.e = l_ctl_r.e - {6'b0, sh};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_ctl_r <= n_ctl_nxt;
      n_m_r   <= n_m_nxt;
    end
  end

  // round to nearest even and pack
  logic        up_d, up_f, hid, ovf;
  logic [53:0] r53;
  logic [24:0] r24;
  logic [11:0] e_sel, field, emax12, bias12;
  logic [63:0] bits_nxt;
  logic        small_nxt;
  logic [63:0] res_bits_r;
  logic        res_small_r;

  always_comb begin
    up_d   = n_m_r[2] & ((|n_m_r[1:0]) | n_m_r[3]);
    up_f   = n_m_r[31] & ((|n_m_r[30:0]) | n_m_r[32]);
    r53    = {1'b0, n_m_r[55:3]} + {53'b0, up_d};
    r24    = {1'b0, n_m_r[55:32]} + {24'b0, up_f};
    emax12 = n_ctl_r.dbl ? 12'h7FF : 12'h0FF;
    bias12 = n_ctl_r.dbl ? 12'h3FF : 12'h07F;
    if (n_ctl_r.dbl) begin
      hid   = r53[53] | r53[52];
      e_sel = n_ctl_r.e + {11'b0, r53[53]};
    end else begin
      hid   = r24[24] | r24[23];
      e_sel = n_ctl_r.e + {11'b0, r24[24]};
    end
    field = hid ? e_sel : 12'd0;
    ovf   = field >= emax12;
    if (n_ctl_r.nan) begin
      bits_nxt  = n_ctl_r.dbl ? 64'h7FF8_0000_0000_0000 : 64'h0000_0000_7FC0_0000;
      small_nxt = 1'b0;
    end else if (n_ctl_r.inf || ovf) begin
      bits_nxt  = n_ctl_r.dbl ? {n_ctl_r.sign, 11'h7FF, 52'b0}
                              : {32'b0, n_ctl_r.sign, 8'hFF, 23'b0};
      small_nxt = 1'b0;
    end else begin
      if (n_ctl_r.dbl) begin
        bits_nxt = {n_ctl_r.sign, field[10:0], r53[53] ? 52'b0 : r53[51:0]};
      end else begin
        bits_nxt = {32'b0, n_ctl_r.sign, field[7:0], r24[24] ? 23'b0 : r24[22:0]};
      end
      small_nxt = field < bias12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_bits_r  <= bits_nxt;
      res_small_r <= small_nxt;
    end
  end

  assign res_bits  = res_bits_r;
  assign res_small = res_small_r;

endmodule

FILE: sv/typed_scan_value_compare.sv
// Top level of the typed scan value compare block: stream ports, integer and
// ordered compares, float adder pipeline, output register.
// Depends on tsvc_pkg, tsvc_cfg, tsvc_fadd.
//
//   channel | dir   | payload                          | handshake
//   in_     | slave | memory_value, extra_value        | tvalid/tready
//   out_    | mastr | match                            | tvalid/tready
//   cfg_    | slave | compare_mode, value_type, scan_value, value_length | APB
//
// One request per cycle while the output is not stalled; each request passes from
// accept to result through one input stage, six stages of the float adder and one
// output register; the adder sets that depth. The whole pipeline moves as one: it
// advances whenever the output register is empty or being taken, so a stall holds
// every stage in place. Reset clears all valid bits and the output match only.
module typed_scan_value_compare
  import tsvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,   // [63:0] memory_value, [127:64] extra_value
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] match, [7:1] zero
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  tsvc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Ordered compare for every type; unused type codes compare false.
  function automatic rel_t rel(input logic [3:0] t, input logic [63:0] a,
                               input logic [63:0] b);
    rel_t        r;
    logic [63:0] xa, xb, ka, kb;
    logic        za, zb, na, nb;
    r  = '0;
    xa = a;
    xb = b;
    if (t == TYPE_F32) begin
      na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      za = a[30:0] == 31'd0;
      zb = b[30:0] == 31'd0;
      ka = {32'b0, a[31] ? ~a[31:0] : {1'b1, a[30:0]}};
      kb = {32'b0, b[31] ? ~b[31:0] : {1'b1, b[30:0]}};
      if (na || nb) begin
        r.ne = 1'b1;
      end else if (za && zb) begin
        r.eq = 1'b1;
      end else begin
        r.gt = ka > kb;
        r.lt = ka < kb;
        r.eq = ka == kb;
        r.ne = ka != kb;
      end
    end else if (t == TYPE_F64) begin
      na = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      nb = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      za = a[62:0] == 63'd0;
      zb = b[62:0] == 63'd0;
      ka = a[63] ? ~a : {1'b1, a[62:0]};
      kb = b[63] ? ~b : {1'b1, b[62:0]};
      if (na || nb) begin
        r.ne = 1'b1;
      end else if (za && zb) begin
        r.eq = 1'b1;
      end else begin
        r.gt = ka > kb;
        r.lt = ka < kb;
        r.eq = ka == kb;
        r.ne = ka != kb;
      end
    end else if (t <= TYPE_I64) begin
      unique case (t[2:1])
        2'd0: begin
          xa = t[0] ? {{56{a[7]}}, a[7:0]} : {56'b0, a[7:0]};
          xb = t[0] ? {{56{b[7]}}, b[7:0]} : {56'b0, b[7:0]};
        end
        2'd1: begin
          xa = t[0] ? {{48{a[15]}}, a[15:0]} : {48'b0, a[15:0]};
          xb = t[0] ? {{48{b[15]}}, b[15:0]} : {48'b0, b[15:0]};
        end
        2'd2: begin
          xa = t[0] ? {{32{a[31]}}, a[31:0]} : {32'b0, a[31:0]};
          xb = t[0] ? {{32{b[31]}}, b[31:0]} : {32'b0, b[31:0]};
        end
        2'd3: begin
          xa = a;
          xb = b;
        end
      endcase
      if (t[0]) begin
        r.gt = $signed(xa) > $signed(xb);
        r.lt = $signed(xa) < $signed(xb);
      end else begin
        r.gt = xa > xb;
        r.lt = xa < xb;
      end
      r.eq = xa == xb;
      r.ne = xa != xb;
    end
    return r;
  endfunction

  function automatic logic [17:0] ext18(input logic [3:0] t, input logic [63:0] v);
    logic [17:0] r;
    unique case (t[1:0])
      2'd0: r = {10'b0, v[7:0]};
      2'd1: r = {{10{v[7]}}, v[7:0]};
      2'd2: r = {2'b0, v[15:0]};
      2'd3: r = {{2{v[15]}}, v[15:0]};
    endcase
    return r;
  endfunction

  // mem == extra +/- scan for integer types; 8- and 16-bit sums do not wrap
  function automatic logic int_off(input logic [3:0] t, input logic [63:0] mem,
                                   input logic [63:0] ext, input logic [63:0] scn,
                                   input logic sub);
    logic [17:0] x, e, s, r18;
    logic [63:0] m, r64;
    logic        hit;
    x   = ext18(t, mem);
    e   = ext18(t, ext);
    s   = ext18(t, scn);
    r18 = sub ? (e - s) : (e + s);
    m   = (t <= TYPE_I32) ? 64'h0000_0000_FFFF_FFFF : {64{1'b1}};
    r64 = sub ? (ext - scn) : (ext + scn);
    if (t <= TYPE_I16) hit = x == r18;
    else if (t <= TYPE_I64) hit = ((r64 ^ mem) & m) == 64'd0;
    else hit = 1'b0;
    return hit;
  endfunction

  function automatic logic fp_eq(input logic dbl, input logic [63:0] a,
                                 input logic [63:0] b);
    logic na, nb, eq;
    if (dbl) begin
      na = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
      nb = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
      eq = (a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0));
    end else begin
      na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      eq = (a[31:0] == b[31:0]) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    end
    return !na && !nb && eq;
  endfunction

  // Whole pipeline advances together
  logic adv;
  logic out_valid_r, out_match_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Input stage
  logic        s1_vld_r;
  logic [63:0] s1_mem_r, s1_ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mem_r <= in_tdata[63:0];
      s1_ext_r <= in_tdata[127:64];
    end
  end

  // Integer, ordered and exact compares, done in the first stage
  logic [3:0]  len_c;
  logic [63:0] len_mask;
  rel_t        r_ms, r_me, r_es;
  logic        hit;

  always_comb begin
    len_c    = (cfg.len > 4'd8) ? 4'd8 : cfg.len;
    len_mask = (len_c == 4'd8) ? {64{1'b1}}
                               : ~({64{1'b1}} << {len_c[2:0], 3'b000});
    r_ms     = rel(cfg.vtype, s1_mem_r, cfg.scan);
    r_me     = rel(cfg.vtype, s1_mem_r, s1_ext_r);
    r_es     = rel(cfg.vtype, s1_ext_r, cfg.scan);
    unique case (cfg.mode)
      MODE_EXACT:     hit = ((s1_mem_r ^ cfg.scan) & len_mask) == 64'd0;
      MODE_GREATER:   hit = r_ms.gt;
      MODE_LESS:      hit = r_ms.lt;
      MODE_BETWEEN:   hit = r_es.gt ? (r_ms.gt && r_me.lt) : (r_ms.lt && r_me.gt);
      MODE_INCR:      hit = r_me.gt;
      MODE_INCR_BY:   hit = int_off(cfg.vtype, s1_mem_r, s1_ext_r, cfg.scan, 1'b0);
      MODE_DECR:      hit = r_me.lt;
      MODE_DECR_BY:   hit = int_off(cfg.vtype, s1_mem_r, s1_ext_r, cfg.scan, 1'b1);
      MODE_CHANGED:   hit = r_me.ne;
      MODE_UNCHANGED: hit = r_me.eq;
      default:        hit = 1'b0;
    endcase
  end

  // Float adder operands: fuzzy takes scan - mem, offset modes extra +/- scan
  logic        is_dbl, is_fp, fa_sub;
  logic [63:0] fa_a, fa_b, fa_bits;
  logic        fa_small;

  assign is_dbl = cfg.vtype == TYPE_F64;
  assign is_fp  = (cfg.vtype == TYPE_F32) || (cfg.vtype == TYPE_F64);
  assign fa_a   = (cfg.mode == MODE_FUZZY) ? cfg.scan : s1_ext_r;
  assign fa_b   = (cfg.mode == MODE_FUZZY) ? s1_mem_r : cfg.scan;
  assign fa_sub = cfg.mode != MODE_INCR_BY;

  tsvc_fadd u_fadd (
    .clk       (clk),
    .en        (adv),
    .dbl       (is_dbl),
    .sub       (fa_sub),
    .op_a      (fa_a),
    .op_b      (fa_b),
    .res_bits  (fa_bits),
    .res_small (fa_small)
  );

  // Side data delayed to line up with the adder result
  logic        dly_vld_r [FADD_STAGES];
  logic        dly_hit_r [FADD_STAGES];
  logic [63:0] dly_mem_r [FADD_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FADD_STAGES; i++) dly_vld_r[i] <= 1'b0;
    end else if (adv) begin
      dly_vld_r[0] <= s1_vld_r;
      for (int i = 1; i < FADD_STAGES; i++) dly_vld_r[i] <= dly_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_hit_r[0] <= hit;
      dly_mem_r[0] <= s1_mem_r;
      for (int i = 1; i < FADD_STAGES; i++) begin
        dly_hit_r[i] <= dly_hit_r[i-1];
        dly_mem_r[i] <= dly_mem_r[i-1];
      end
    end
  end

  // Final select into the output register
  logic match_nxt;

  always_comb begin
    unique case (cfg.mode)
      MODE_FUZZY:   match_nxt = is_fp && fa_small;
      MODE_INCR_BY,
      MODE_DECR_BY: match_nxt = is_fp ? fp_eq(is_dbl, dly_mem_r[FADD_STAGES-1], fa_bits)
                                      : dly_hit_r[FADD_STAGES-1];
      default:      match_nxt = dly_hit_r[FADD_STAGES-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_match_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dly_vld_r[FADD_STAGES-1];
      out_match_r <= match_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_match_r};

endmodule
